/* sv/plll_pkg.sv */
// Package for the piecewise-linear limit lookup unit.
// Holds the breakpoint entry type, the item, status and column codes and the register map.
// No dependencies.
package plll_pkg;

  localparam int NUM_CFG = 3;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 6;
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 32;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  localparam logic COL_LOWER = 1'b0;
  localparam logic COL_UPPER = 1'b1;

  localparam logic [CFG_IW-1:0] REG_HEAD_POINTS  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_LEFT_POINTS  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_RIGHT_POINTS = 2'd2;

  typedef struct packed {
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
  } bp_entry_t;

  function automatic logic signed [VAL_W-1:0] col_val(bp_entry_t e, logic col);
    logic signed [VAL_W-1:0] v;
    v = (col == COL_UPPER) ? e.hi : e.lo;
    return v;
  endfunction

endpackage

/* sv/piecewise_linear_limit_lookup_unit.sv */
// Piecewise-linear limit lookup unit: breakpoint store, segment scan and divider.
// Depends on plll_pkg.
//
// One item is processed at a time. A write item, and a query of an empty table, goes from
// acceptance through S_DONE to the output register. A query of a table of n breakpoints
// passes through one read of the first entry, one of the last, a scan of up to n-1 entries
// through the single read port of the breakpoint memory (one entry per cycle), a multiply,
// a bit-serial restoring divider over the 32-bit product, a final add and the load of the
// output register. The next item can be taken as soon as the result sits in the output
// register; a stalled result holds the next result in S_DONE until it is taken.
module piecewise_linear_limit_lookup_unit #(
  parameter int MAX_POINTS = 32,
  parameter int NUM_TABLES = 3
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [plll_pkg::CFG_IW-1:0]         cfg_index_i,
  input  logic [plll_pkg::CFG_DW-1:0]         cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                func_i,
  input  logic [1:0]                          table_sel_i,
  input  logic [4:0]                          entry_index_i,
  input  logic signed [plll_pkg::VAL_W-1:0]   angle_i,
  input  logic signed [plll_pkg::VAL_W-1:0]   lower_limit_i,
  input  logic signed [plll_pkg::VAL_W-1:0]   upper_limit_i,
  input  logic                                column_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [plll_pkg::VAL_W-1:0]   result_o,
  output logic                                status_o
);

  localparam int PW    = $clog2(MAX_POINTS);
  localparam int TW    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int AW    = TW + PW;
  localparam int DEPTH = 2 ** AW;
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int EW    = (CW > plll_pkg::CFG_DW) ? CW : plll_pkg::CFG_DW;
  localparam int VW    = plll_pkg::VAL_W;
  localparam int MW    = plll_pkg::PROD_W;

  typedef enum logic [2:0] {
    S_IDLE, S_FIRST, S_LAST, S_SCAN, S_MUL, S_DIV, S_FIX, S_DONE
  } state_e;

  // config registers
  logic [plll_pkg::CFG_DW-1:0] cfg_q [plll_pkg::NUM_CFG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < plll_pkg::NUM_CFG; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_we_i && (32'(cfg_index_i) < plll_pkg::NUM_CFG)) begin
      cfg_q[cfg_index_i] <= cfg_wdata_i;
    end
  end

  // breakpoint memory
  plll_pkg::bp_entry_t mem [DEPTH];
  plll_pkg::bp_entry_t rdata_q;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [AW-1:0]       rd_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= '{x: angle_i, lo: lower_limit_i, hi: upper_limit_i};
    end
    rdata_q <= mem[rd_addr];
  end

  state_e                    state_q;
  logic [TW-1:0]             tab_q;
  logic [CW-1:0]             n_q;
  logic [CW-1:0]             k_q;
  logic signed [VW-1:0]      ang_q;
  logic                      col_q;
  plll_pkg::bp_entry_t       prev_q;
  logic signed [VW-1:0]      y0_q;
  logic                      neg_q;
  logic [VW-1:0]             dymag_q;
  logic [VW-1:0]             off_q;
  logic [VW-1:0]             dx_q;
  logic [plll_pkg::PROD_W-1:0] dvd_q;
  logic [VW-1:0]             rem_q;
  logic [4:0]                dcnt_q;
  logic signed [VW-1:0]      res_q;
  logic                      stat_q;
  logic signed [VW-1:0]      result_q;
  logic                      status_q;
  logic                      out_valid_q;

  logic                      in_acc;
  logic                      tsel_ok;
  logic [EW-1:0]             cnt_ext;
  logic [CW-1:0]             n_in;
  logic [CW-1:0]             n_m1;
  logic [CW-1:0]             k_p1;
  logic signed [VW-1:0]      y0_w;
  logic signed [VW-1:0]      y1_w;
  logic signed [VW:0]        dy_w;
  logic [VW:0]               dyabs_w;
  logic signed [VW:0]        off_w;
  logic signed [VW:0]        dx_w;
  logic                      hit_w;
  logic [VW+1:0]             diff_w;
  logic [VW-1:0]             q_w;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign status_o    = status_q;

  always_comb begin
    tsel_ok = (32'(table_sel_i) < NUM_TABLES) && (32'(table_sel_i) < plll_pkg::NUM_CFG);
    cnt_ext = tsel_ok ? EW'(cfg_q[table_sel_i]) : '0;
    n_in    = (cnt_ext > EW'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(cnt_ext);
  end

  assign mem_we    = in_acc && (func_i == plll_pkg::FUNC_WRITE)
                     && (32'(table_sel_i) < NUM_TABLES) && (32'(entry_index_i) < MAX_POINTS);
  assign mem_waddr = {TW'(table_sel_i), PW'(entry_index_i)};

  assign n_m1 = n_q - 1'b1;
  assign k_p1 = k_q + 1'b1;

  always_comb begin
    case (state_q)
      S_IDLE:  rd_addr = {TW'(table_sel_i), PW'(0)};
      S_FIRST: rd_addr = {tab_q, n_m1[PW-1:0]};
      S_LAST:  rd_addr = {tab_q, PW'(1)};
      S_SCAN:  rd_addr = {tab_q, k_p1[PW-1:0]};
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    y0_w    = plll_pkg::col_val(prev_q, col_q);
    y1_w    = plll_pkg::col_val(rdata_q, col_q);
    dy_w    = {y1_w[VW-1], y1_w} - {y0_w[VW-1], y0_w};
    dyabs_w = dy_w[VW] ? -dy_w : dy_w;
    off_w   = {ang_q[VW-1], ang_q} - {prev_q.x[VW-1], prev_q.x};
    dx_w    = {rdata_q.x[VW-1], rdata_q.x} - {prev_q.x[VW-1], prev_q.x};
    hit_w   = (ang_q > prev_q.x) && (ang_q <= rdata_q.x);
    diff_w  = {1'b0, rem_q, dvd_q[plll_pkg::PROD_W-1]} - {2'b00, dx_q};
    q_w     = dvd_q[VW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tab_q       <= '0;
      n_q         <= '0;
      k_q         <= '0;
      ang_q       <= '0;
      col_q       <= 1'b0;
      prev_q      <= '0;
      y0_q        <= '0;
      neg_q       <= 1'b0;
      dymag_q     <= '0;
      off_q       <= '0;
      dx_q        <= '0;
      dvd_q       <= '0;
      rem_q       <= '0;
      dcnt_q      <= '0;
      res_q       <= '0;
      stat_q      <= plll_pkg::STATUS_OK;
      result_q    <= '0;
      status_q    <= plll_pkg::STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            tab_q  <= TW'(table_sel_i);
            n_q    <= n_in;
            ang_q  <= angle_i;
            col_q  <= column_i;
            res_q  <= '0;
            stat_q <= plll_pkg::STATUS_OK;
            if (func_i == plll_pkg::FUNC_WRITE) begin
              state_q <= S_DONE;
            end else if (n_in == '0) begin
              stat_q  <= plll_pkg::STATUS_EMPTY;
              state_q <= S_DONE;
            end else begin
              state_q <= S_FIRST;
            end
          end
        end
        S_FIRST: begin
          prev_q <= rdata_q;
          if (ang_q <= rdata_q.x) begin
            res_q   <= y1_w;
            state_q <= S_DONE;
          end else begin
            state_q <= S_LAST;
          end
        end
        S_LAST: begin
          k_q <= CW'(1);
          if (ang_q >= rdata_q.x) begin
            res_q   <= y1_w;
            state_q <= S_DONE;
          end else begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit_w) begin
            y0_q    <= y0_w;
            neg_q   <= dy_w[VW];
            dymag_q <= dyabs_w[VW-1:0];
            off_q   <= off_w[VW-1:0];
            dx_q    <= dx_w[VW-1:0];
            state_q <= S_MUL;
          end else if (k_q == n_m1) begin
            state_q <= S_DONE;
          end else begin
            prev_q <= rdata_q;
            k_q    <= k_p1;
          end
        end
        S_MUL: begin
          dvd_q   <= MW'(dymag_q) * MW'(off_q);
          rem_q   <= '0;
          dcnt_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q  <= diff_w[VW+1] ? {rem_q[VW-2:0], dvd_q[plll_pkg::PROD_W-1]} : diff_w[VW-1:0];
          dvd_q  <= {dvd_q[plll_pkg::PROD_W-2:0], ~diff_w[VW+1]};
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == 5'd31) begin
            state_q <= S_FIX;
          end
        end
        S_FIX: begin
          res_q   <= neg_q ? (y0_q - $signed(q_w)) : (y0_q + $signed(q_w));
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            result_q    <= res_q;
            status_q    <= stat_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/plll_checker.sv */
// Port-level checker for the piecewise-linear limit lookup unit, bound to the top level.
// Depends on plll_pkg and piecewise_linear_limit_lookup_unit.
module plll_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [plll_pkg::VAL_W-1:0] result_o,
  input logic                              status_o
);

  logic [1:0] pend_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_o) && $stable(status_o))
    else $error("result item changed while stalled");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == plll_pkg::STATUS_EMPTY) |-> result_o == '0)
    else $error("empty-table status with nonzero result");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("ready while an item is in progress");

  a_no_extra_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result item without an accepted item");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> pend_q <= 2'd1)
    else $error("more than two items outstanding");

endmodule

bind piecewise_linear_limit_lookup_unit plll_checker u_plll_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .result_o    (result_o),
  .status_o    (status_o)
);

/* test/piecewise_linear_limit_lookup_unit_tb.sv */
// Self-checking testbench for the piecewise-linear limit lookup unit.
// Random writes/queries with random handshake gaps, checked against a built-in predictor.
// Depends on plll_pkg and piecewise_linear_limit_lookup_unit.
module piecewise_linear_limit_lookup_unit_tb;

  localparam int MAX_POINTS  = 32;
  localparam int NUM_TABLES  = 3;
  localparam int ITEM_TARGET = 1450;
  localparam int IDLE_PCT    = 6;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 80;
  localparam int VW          = plll_pkg::VAL_W;
  localparam int CFG_W       = plll_pkg::CFG_DW;
  localparam logic [plll_pkg::CFG_IW-1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic                 func;
    logic [1:0]           sel;
    logic [4:0]           idx;
    logic signed [VW-1:0] ang;
    logic signed [VW-1:0] lo;
    logic signed [VW-1:0] hi;
    logic                 col;
  } limit_request_t;

  typedef struct {
    logic signed [VW-1:0] value;
    logic                 status;
  } limit_answer_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [plll_pkg::CFG_IW-1:0]   cfg_index_i = '0;
  logic [CFG_W-1:0]              cfg_wdata_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic                          func_i = 1'b0;
  logic [1:0]                    table_sel_i = '0;
  logic [4:0]                    entry_index_i = '0;
  logic signed [VW-1:0]          angle_i = '0;
  logic signed [VW-1:0]          lower_limit_i = '0;
  logic signed [VW-1:0]          upper_limit_i = '0;
  logic                          column_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic signed [VW-1:0]          result_o;
  logic                          status_o;

  piecewise_linear_limit_lookup_unit #(
    .MAX_POINTS(MAX_POINTS),
    .NUM_TABLES(NUM_TABLES)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .func_i(func_i),
    .table_sel_i(table_sel_i),
    .entry_index_i(entry_index_i),
    .angle_i(angle_i),
    .lower_limit_i(lower_limit_i),
    .upper_limit_i(upper_limit_i),
    .column_i(column_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .result_o(result_o),
    .status_o(status_o)
  );

  // predictor state
  plll_pkg::bp_entry_t bp_store [NUM_TABLES][MAX_POINTS];
  logic [CFG_W-1:0]    points_mirror [plll_pkg::NUM_CFG];

  // generator state
  int  gen_x       [NUM_TABLES][MAX_POINTS];
  bit  gen_written [NUM_TABLES][MAX_POINTS];
  int  gen_count   [NUM_TABLES];
  int  item_total = 0;

  limit_request_t queued_requests[$];
  limit_answer_t  expected_limits[$];
  limit_request_t drive_request;
  limit_answer_t  oldest_limit;
  bit             quiet = 1'b0;
  int             mismatch_count = 0;
  int             stall_cycles = 0;
  bit             timed_out = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int pick_col(plll_pkg::bp_entry_t e, logic col);
    return (col == plll_pkg::COL_UPPER) ? int'(e.hi) : int'(e.lo);
  endfunction

  function automatic limit_answer_t predict_limit(limit_request_t rq);
    limit_answer_t ans;
    int     n;
    int     a;
    bit     found;
    longint y0, dy, dx, off, q;
    ans.value  = '0;
    ans.status = plll_pkg::STATUS_OK;
    if (rq.func == plll_pkg::FUNC_WRITE) begin
      if (rq.sel < NUM_TABLES) begin
        bp_store[rq.sel][rq.idx].x  = rq.ang;
        bp_store[rq.sel][rq.idx].lo = rq.lo;
        bp_store[rq.sel][rq.idx].hi = rq.hi;
      end
      return ans;
    end
    n = 0;
    if (rq.sel < NUM_TABLES && rq.sel < plll_pkg::NUM_CFG) n = int'(points_mirror[rq.sel]);
    if (n > MAX_POINTS) n = MAX_POINTS;
    if (n == 0) begin
      ans.status = plll_pkg::STATUS_EMPTY;
      return ans;
    end
    a = rq.ang;
    if (a <= int'(bp_store[rq.sel][0].x)) begin
      ans.value = 16'(pick_col(bp_store[rq.sel][0], rq.col));
    end else if (a >= int'(bp_store[rq.sel][n-1].x)) begin
      ans.value = 16'(pick_col(bp_store[rq.sel][n-1], rq.col));
    end else begin
      found = 1'b0;
      for (int k = 0; k + 1 < n; k++) begin
        if (!found && a > int'(bp_store[rq.sel][k].x) && a <= int'(bp_store[rq.sel][k+1].x)) begin
          found = 1'b1;
          y0  = pick_col(bp_store[rq.sel][k], rq.col);
          dy  = longint'(pick_col(bp_store[rq.sel][k+1], rq.col)) - y0;
          dx  = longint'(bp_store[rq.sel][k+1].x) - longint'(bp_store[rq.sel][k].x);
          off = longint'(a) - longint'(bp_store[rq.sel][k].x);
          q   = (dy * off) / dx;
          ans.value = 16'(y0 + q);
        end
      end
    end
    return ans;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_limits.insert(expected_limits.size(), predict_limit(drive_request));
      end
      if (!in_valid_i || in_ready_o) begin
        if (queued_requests.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          drive_request = queued_requests.pop_front();
          in_valid_i    <= 1'b1;
          func_i        <= drive_request.func;
          table_sel_i   <= drive_request.sel;
          entry_index_i <= drive_request.idx;
          angle_i       <= drive_request.ang;
          lower_limit_i <= drive_request.lo;
          upper_limit_i <= drive_request.hi;
          column_i      <= drive_request.col;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_limits.size() == 0) begin
        $display("%0t: unexpected item: expected none, actual result %0d status %0d",
                 $time, result_o, status_o);
        mismatch_count++;
      end else begin
        oldest_limit = expected_limits.pop_front();
        if (result_o !== oldest_limit.value) begin
          $display("%0t: result mismatch: expected %0d, actual %0d",
                   $time, oldest_limit.value, result_o);
          mismatch_count++;
        end
        if (status_o !== oldest_limit.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, oldest_limit.status, status_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      timed_out <= 1'b1;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic int rand16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic push_item(logic f, int sel, int idx, int ang, int lo, int hi, logic col);
    limit_request_t rq;
    rq.func = f;
    rq.sel  = 2'(sel);
    rq.idx  = 5'(idx);
    rq.ang  = 16'(ang);
    rq.lo   = 16'(lo);
    rq.hi   = 16'(hi);
    rq.col  = col;
    queued_requests.insert(queued_requests.size(), rq);
    if (f == plll_pkg::FUNC_WRITE && sel < NUM_TABLES) begin
      gen_written[sel][idx] = 1'b1;
      gen_x[sel][idx]       = ang;
    end
    item_total++;
  endtask

  task automatic push_query(int t);
    int n;
    int pick;
    int a;
    int lo_x;
    int hi_x;
    n = 0;
    if (t < NUM_TABLES) n = gen_count[t];
    pick = $urandom_range(0, 9);
    if (n == 0 || pick >= 7) begin
      a = rand16();
    end else if (pick <= 2) begin
      a = gen_x[t][$urandom_range(0, n - 1)];
    end else if (pick <= 4) begin
      a = gen_x[t][$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
      if (a > 32767) a = 32767;
      if (a < -32768) a = -32768;
    end else if (pick == 5) begin
      lo_x = (gen_x[t][0] < gen_x[t][n-1]) ? gen_x[t][0] : gen_x[t][n-1];
      hi_x = (gen_x[t][0] < gen_x[t][n-1]) ? gen_x[t][n-1] : gen_x[t][0];
      a = lo_x + int'($urandom_range(0, hi_x - lo_x));
    end else begin
      a = $urandom_range(0, 1) ? 32767 : -32768;
    end
    push_item(plll_pkg::FUNC_QUERY, t, $urandom_range(0, 31), a, rand16(), rand16(),
              1'($urandom_range(0, 1)));
  endtask

  // shapes: unsorted, full span with swinging limits, ascending with repeats, ascending
  task automatic fill_table(int t, int n);
    int shape;
    int step_hi;
    int total;
    int x;
    int xs;
    int incr [MAX_POINTS];
    shape   = $urandom_range(0, 9);
    step_hi = $urandom_range(1, 65535 / n);
    total   = 0;
    for (int k = 1; k < n; k++) begin
      incr[k] = (shape == 2 && $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, step_hi);
      total += incr[k];
    end
    x = (shape == 1) ? -32768 : -32768 + int'($urandom_range(0, 65535 - total));
    for (int k = 0; k < n; k++) begin
      if (k > 0) x += incr[k];
      xs = x;
      if (shape == 1 && k == n - 1 && n > 1) xs = 32767;
      if (shape == 0) xs = rand16();
      if (shape == 1) begin
        push_item(plll_pkg::FUNC_WRITE, t, k, xs, (k % 2) ? 32767 : -32768,
                  (k % 2) ? -32768 : 32767, 1'($urandom_range(0, 1)));
      end else begin
        push_item(plll_pkg::FUNC_WRITE, t, k, xs, rand16(), rand16(),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic run_mix(int count);
    int r;
    int t;
    repeat (count) begin
      r = $urandom_range(0, 99);
      t = $urandom_range(0, NUM_TABLES - 1);
      if (r < 72) begin
        push_query(t);
      end else if (r < 75) begin
        push_query(3);
      end else if (r < 79) begin
        push_item(plll_pkg::FUNC_WRITE, 3, $urandom_range(0, 31), rand16(), rand16(),
                  rand16(), 1'($urandom_range(0, 1)));
      end else if (r < 82 && gen_count[t] > 0) begin
        push_item(plll_pkg::FUNC_WRITE, t, $urandom_range(0, gen_count[t] - 1), rand16(),
                  rand16(), rand16(), 1'($urandom_range(0, 1)));
      end else if (gen_count[t] < MAX_POINTS) begin
        push_item(plll_pkg::FUNC_WRITE, t, $urandom_range(gen_count[t], MAX_POINTS - 1),
                  rand16(), rand16(), rand16(), 1'($urandom_range(0, 1)));
      end else begin
        push_query(t);
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (queued_requests.size() != 0 || in_valid_i || expected_limits.size() != 0);
  endtask

  task automatic write_points(logic [CFG_W-1:0] h, logic [CFG_W-1:0] l,
                              logic [CFG_W-1:0] r, bit spare);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= plll_pkg::REG_HEAD_POINTS;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_index_i <= plll_pkg::REG_LEFT_POINTS;
    cfg_wdata_i <= l;
    @(posedge clk_i);
    cfg_index_i <= plll_pkg::REG_RIGHT_POINTS;
    cfg_wdata_i <= r;
    if (spare) begin
      @(posedge clk_i);
      cfg_index_i <= REG_SPARE;
      cfg_wdata_i <= '1;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    points_mirror[plll_pkg::REG_HEAD_POINTS]  = h;
    points_mirror[plll_pkg::REG_LEFT_POINTS]  = l;
    points_mirror[plll_pkg::REG_RIGHT_POINTS] = r;
    for (int t = 0; t < NUM_TABLES; t++) begin
      gen_count[t] = (points_mirror[t] > MAX_POINTS) ? MAX_POINTS : int'(points_mirror[t]);
    end
  endtask

  function automatic logic [CFG_W-1:0] pick_points();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return CFG_W'(0);
      1:       return CFG_W'(1);
      2:       return CFG_W'(2);
      7:       return CFG_W'($urandom_range(9, 31));
      8:       return CFG_W'(MAX_POINTS);
      9:       return CFG_W'($urandom_range(33, 63));
      default: return CFG_W'($urandom_range(3, 8));
    endcase
  endfunction

  initial begin
    logic [CFG_W-1:0] cnt [NUM_TABLES];
    int  phase;
    bit  full;
    for (int t = 0; t < NUM_TABLES; t++) begin
      gen_count[t] = 0;
      for (int k = 0; k < MAX_POINTS; k++) gen_written[t][k] = 1'b0;
    end
    for (int i = 0; i < plll_pkg::NUM_CFG; i++) points_mirror[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    fork
      begin
        // all tables empty after reset; out-of-range table writes are dropped
        push_item(plll_pkg::FUNC_QUERY, 0, 0, 0, 0, 0, plll_pkg::COL_LOWER);
        push_item(plll_pkg::FUNC_QUERY, 1, 31, 0, 0, 0, plll_pkg::COL_UPPER);
        push_item(plll_pkg::FUNC_QUERY, 2, 0, 0, 0, 0, plll_pkg::COL_LOWER);
        push_item(plll_pkg::FUNC_QUERY, 3, 0, 0, 0, 0, plll_pkg::COL_UPPER);
        push_item(plll_pkg::FUNC_WRITE, 3, 31, -32768, 32767, -32768, plll_pkg::COL_LOWER);
        push_item(plll_pkg::FUNC_WRITE, 0, 0, 256, -1000, 1000, plll_pkg::COL_LOWER);
        push_item(plll_pkg::FUNC_WRITE, 1, 0, -32768, -32768, 32767, plll_pkg::COL_LOWER);
        push_item(plll_pkg::FUNC_WRITE, 1, 1, 32767, 32767, -32768, plll_pkg::COL_UPPER);
        push_item(plll_pkg::FUNC_WRITE, 2, 0, 100, 400, -400, plll_pkg::COL_LOWER);
        push_item(plll_pkg::FUNC_WRITE, 2, 1, -300, -32768, 32767, plll_pkg::COL_LOWER);
        push_item(plll_pkg::FUNC_WRITE, 2, 2, 500, 32767, 0, plll_pkg::COL_LOWER);
        wait_idle();
        write_points(1, 2, 3, 1'b1);
        // single breakpoint
        push_item(plll_pkg::FUNC_QUERY, 0, 0, 255, 0, 0, plll_pkg::COL_LOWER);
        push_item(plll_pkg::FUNC_QUERY, 0, 0, 256, 0, 0, plll_pkg::COL_UPPER);
        push_item(plll_pkg::FUNC_QUERY, 0, 0, 32767, 0, 0, plll_pkg::COL_LOWER);
        // full-span segment, largest products
        push_item(plll_pkg::FUNC_QUERY, 1, 0, -32768, 0, 0, plll_pkg::COL_LOWER);
        push_item(plll_pkg::FUNC_QUERY, 1, 0, 32767, 0, 0, plll_pkg::COL_UPPER);
        push_item(plll_pkg::FUNC_QUERY, 1, 0, 32766, 0, 0, plll_pkg::COL_LOWER);
        push_item(plll_pkg::FUNC_QUERY, 1, 0, 32766, 0, 0, plll_pkg::COL_UPPER);
        push_item(plll_pkg::FUNC_QUERY, 1, 0, 0, 0, 0, plll_pkg::COL_UPPER);
        // unsorted breakpoints
        push_item(plll_pkg::FUNC_QUERY, 2, 0, 200, 0, 0, plll_pkg::COL_LOWER);
        push_item(plll_pkg::FUNC_QUERY, 2, 0, 100, 0, 0, plll_pkg::COL_UPPER);
        push_item(plll_pkg::FUNC_QUERY, 2, 0, -32768, 0, 0, plll_pkg::COL_UPPER);
        push_item(plll_pkg::FUNC_QUERY, 3, 0, 0, 0, 0, plll_pkg::COL_LOWER);

        phase = 0;
        while (item_total < ITEM_TARGET) begin
          wait_idle();
          case (phase)
            0:       cnt = '{6'd63, 6'd32, 6'd0};
            1:       cnt = '{6'd1, 6'd63, 6'd32};
            2:       cnt = '{6'd32, 6'd0, 6'd63};
            default: cnt = '{pick_points(), pick_points(), pick_points()};
          endcase
          write_points(cnt[0], cnt[1], cnt[2], phase == 3);
          quiet = (phase == 4);
          for (int t = 0; t < NUM_TABLES; t++) begin
            if (gen_count[t] > 0) begin
              full = 1'b1;
              for (int k = 0; k < gen_count[t]; k++) full &= gen_written[t][k];
              if (!full || $urandom_range(0, 9) < 7) fill_table(t, gen_count[t]);
            end
          end
          run_mix(quiet ? 300 : $urandom_range(40, 120));
          phase++;
        end
        wait_idle();
        quiet = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk_i);
      end
      wait (timed_out);
    join_any

    if (!timed_out && mismatch_count == 0 && expected_limits.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
